// ===== design/newline_frame_assembler_unit_defines.svh =====
// assertion macros for the frame assembler sequencer
`ifndef NEWLINE_FRAME_ASSEMBLER_UNIT_DEFINES_SVH
`define NEWLINE_FRAME_ASSEMBLER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nfa_pkg.sv =====
// shared constants and types of the newline frame assembler
package nfa_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    localparam logic [BYTE_W-1:0] LINE_FEED       = 8'h0A;
    localparam logic [BYTE_W-1:0] CARRIAGE_RETURN = 8'h0D;

    // result kinds carried on tuser
    localparam logic KIND_FRAME    = 1'b0;
    localparam logic KIND_OVERSIZE = 1'b1;

    // request from the sequencer to load the output register
    typedef struct packed {
        logic             load;
        logic             kind;
        logic             last;
        logic [LEN_W-1:0] len;
    } t_out_req;

endpackage

// ===== design/nfa_frame_mem.sv =====
// frame byte store: one write port, one registered read port
module nfa_frame_mem
    import nfa_pkg::*;
#(
    parameter int DEPTH  = MAX_FRAME_BYTES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/nfa_ctrl.sv =====
// frame sequencer: fills the store, tracks discard and drives the readout
module nfa_ctrl
    import nfa_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int ADDR_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1,
    parameter int CNT_W  = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_in_ready,
    input  logic              i_out_free,
    output t_out_req          o_out_req,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr
);

    `include "newline_frame_assembler_unit_defines.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_NOTE
    } t_state;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_discard, n_discard;
    logic             r_last_cr, n_last_cr;
    logic [CNT_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_idx, n_idx;

    logic             in_acc;
    logic             is_lf;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] frame_len;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign is_lf     = (i_in_byte == LINE_FEED);
    assign idx_inc   = r_idx + 1'b1;
    assign frame_len = r_fill - CNT_W'(r_last_cr);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_wr_addr  = r_fill[ADDR_W-1:0];

    // next state and memory port control
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_discard = r_discard;
        n_last_cr = r_last_cr;
        n_len     = r_len;
        n_idx     = r_idx;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_out_req = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_lf) begin
                        n_fill    = '0;
                        n_last_cr = 1'b0;
                        if (r_discard) begin
                            // end of an oversized frame
                            n_discard = 1'b0;
                            n_state   = S_NOTE;
                        end else if (frame_len != '0) begin
                            // start readout at the first byte
                            n_len     = frame_len;
                            n_idx     = '0;
                            o_rd_en   = 1'b1;
                            o_rd_addr = '0;
                            n_state   = S_LOAD;
                        end
                    end else if (!r_discard) begin
                        if (r_fill >= MAX_CNT) begin
                            // store full: drop and discard to line end
                            n_discard = 1'b1;
                            n_fill    = '0;
                            n_last_cr = 1'b0;
                        end else begin
                            o_wr_en   = 1'b1;
                            n_fill    = r_fill + 1'b1;
                            n_last_cr = (i_in_byte == CARRIAGE_RETURN);
                        end
                    end
                end
            end
            S_LOAD: begin
                if (i_out_free) begin
                    o_out_req.load = 1'b1;
                    o_out_req.kind = KIND_FRAME;
                    o_out_req.last = (idx_inc == r_len);
                    o_out_req.len  = LEN_W'(r_len);
                    if (idx_inc < r_len) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = idx_inc[ADDR_W-1:0];
                        n_idx     = idx_inc;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NOTE: begin
                if (i_out_free) begin
                    o_out_req.load = 1'b1;
                    o_out_req.kind = KIND_OVERSIZE;
                    o_out_req.last = 1'b1;
                    o_out_req.len  = '0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_discard <= 1'b0;
            r_last_cr <= 1'b0;
            r_len     <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_discard <= n_discard;
            r_last_cr <= n_last_cr;
            r_len     <= n_len;
            r_idx     <= n_idx;
        end
    end

    // checks on the sequencer
    `NFA_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= MAX_CNT, "fill count above store depth")
    `NFA_ASSERT_IMP(a_discard_empty, r_discard, r_fill == '0, "fill count set while discarding")
    `NFA_ASSERT_IMP(a_load_idx, r_state == S_LOAD, (r_idx < r_len) && (r_len != '0),
        "readout index outside frame")
    `NFA_ASSERT_IMP(a_cr_flag, r_last_cr, r_fill != '0, "carriage return flag with empty store")
    `NFA_ASSERT_NEXT(a_lf_clears, in_acc && is_lf, r_fill == '0 && !r_discard,
        "line feed did not clear the frame")

endmodule

// ===== design/newline_frame_assembler_unit.sv =====
// Newline frame assembler: bytes are stored as they are accepted; no result until a line feed.
// After a line feed, the first frame byte passes the registered store read into the output register, and
// then one byte per cycle while the output is taken; the single store read port sets this.
// An oversized notice is loaded once the output register is free. Input is held off during readout.
// Synchronous active-low reset clears the fill count, discard flag, sequencer and output
// valid; the byte store itself is not cleared.
module newline_frame_assembler_unit
    import nfa_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] frame_byte, [14:8] line_len, [15] zero
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast    // last_of_run
);

    localparam int ADDR_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);

    t_out_req          out_req;
    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    logic              r_out_valid;
    logic              r_out_kind;
    logic              r_out_last;
    logic [BYTE_W-1:0] r_out_byte;
    logic [LEN_W-1:0]  r_out_len;

    assign out_free = !r_out_valid || m_axis_tready;

    nfa_frame_mem #(
        .DEPTH  (MAX_FRAME_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    nfa_ctrl #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .ADDR_W          (ADDR_W),
        .CNT_W           (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_byte  (s_axis_tdata),
        .o_in_ready (s_axis_tready),
        .i_out_free (out_free),
        .o_out_req  (out_req),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    // output register, one request held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_req.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_req.load) begin
            r_out_kind <= out_req.kind;
            r_out_last <= out_req.last;
            r_out_len  <= out_req.len;
            r_out_byte <= (out_req.kind == KIND_OVERSIZE) ? '0 : rd_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_len, r_out_byte};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sim/newline_frame_assembler_unit_test.sv =====
// self-checking testbench for the newline frame assembler unit
`timescale 1ns / 1ps

module newline_frame_assembler_unit_test;
    import nfa_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 16;
    localparam int          PHASE_BYTES  = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // one output request as the block should present it
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] fbyte;
        logic [LEN_W-1:0]  flen;
        logic              flast;
    } t_frame_result;

    // directed row: a byte sent reps times, optionally with a typed-in outcome
    typedef struct packed {
        logic [7:0]    rx;
        logic [7:0]    reps;
        logic          typed;
        logic          n_typed;
        t_frame_result typed_res;
    } t_directed_row;

    localparam t_frame_result NO_RESULT       = '0;
    localparam t_frame_result OVERSIZE_NOTICE = '{KIND_OVERSIZE, 8'h00, 7'd0, 1'b1};

    localparam int N_ROWS = 22;
    localparam t_directed_row DIRECTED_ROWS [N_ROWS] = '{
        // single byte frame, then an empty line
        '{8'h41, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{LINE_FEED, 8'd1, 1'b1, 1'b1, '{KIND_FRAME, 8'h41, 7'd1, 1'b1}},
        '{LINE_FEED, 8'd1, 1'b1, 1'b0, NO_RESULT},
        // carriage return only
        '{CARRIAGE_RETURN, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{LINE_FEED, 8'd1, 1'b1, 1'b0, NO_RESULT},
        // zero byte with trailing carriage return stripped
        '{8'h00, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{CARRIAGE_RETURN, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{LINE_FEED, 8'd1, 1'b1, 1'b1, '{KIND_FRAME, 8'h00, 7'd1, 1'b1}},
        // carriage return not at the end is kept
        '{CARRIAGE_RETURN, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{LINE_FEED, 8'd1, 1'b0, 1'b0, NO_RESULT},
        // only one of two carriage returns stripped
        '{CARRIAGE_RETURN, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{CARRIAGE_RETURN, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{LINE_FEED, 8'd1, 1'b1, 1'b1, '{KIND_FRAME, CARRIAGE_RETURN, 7'd1, 1'b1}},
        // exactly full store
        '{8'hAA, 8'd63, 1'b0, 1'b0, NO_RESULT},
        '{8'h55, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{LINE_FEED, 8'd1, 1'b0, 1'b0, NO_RESULT},
        // overflow, bytes ignored while discarding
        '{8'h80, 8'd64, 1'b0, 1'b0, NO_RESULT},
        '{8'h7F, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{CARRIAGE_RETURN, 8'd1, 1'b0, 1'b0, NO_RESULT},
        '{LINE_FEED, 8'd1, 1'b1, 1'b1, OVERSIZE_NOTICE},
        // empty line after a notice
        '{LINE_FEED, 8'd1, 1'b1, 1'b0, NO_RESULT}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [7:0] frame_byte, [14:8] line_len, [15] zero
    logic        m_axis_tuser;          // [0] result_kind
    logic        m_axis_tlast;

    // predictor state
    logic [BYTE_W-1:0] line_buf [MAX_FRAME_BYTES_DEF];
    int unsigned       line_fill    = 0;
    bit                dropping     = 1'b0;

    t_frame_result     frame_q [$];
    int unsigned       mismatches   = 0;
    int unsigned       rx_sent      = 0;
    int unsigned       cycle_count  = 0;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    bit                hold_rx_req  = 1'b0;
    t_frame_result     got_res;
    t_frame_result     want_res;

    newline_frame_assembler_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // update line state for one accepted byte, queue the frame results it causes
    function automatic void predict_frame(input logic [7:0] rx, input bit keep);
        int unsigned   run_len;
        int unsigned   k;
        t_frame_result res;
        if (dropping) begin
            if (rx == LINE_FEED) begin
                dropping  = 1'b0;
                line_fill = 0;
                if (keep) frame_q.push_back(OVERSIZE_NOTICE);
            end
        end else if (rx == LINE_FEED) begin
            run_len = line_fill;
            if (run_len > 0 && line_buf[run_len-1] == CARRIAGE_RETURN) run_len--;
            line_fill = 0;
            for (k = 0; keep && k < run_len; k++) begin
                res.kind  = KIND_FRAME;
                res.fbyte = line_buf[k];
                res.flen  = LEN_W'(run_len);
                res.flast = (k + 1 == run_len);
                frame_q.push_back(res);
            end
        end else if (line_fill >= MAX_FRAME_BYTES_DEF) begin
            dropping  = 1'b1;
            line_fill = 0;
        end else begin
            line_buf[line_fill] = rx;
            line_fill++;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // offer one byte, with random idle cycles ahead of it, and predict once taken
    task automatic send_rx_byte(input logic [7:0] rx, input bit typed, input bit n_typed,
                                input t_frame_result typed_res);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_frame(rx, !typed);
        if (typed && n_typed) frame_q.push_back(typed_res);
        rx_sent++;
    endtask

    // mostly well-formed lines, some oversized, some noise
    task automatic send_random_line();
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 8) begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++) begin
                b = ($urandom_range(3) == 0) ? LINE_FEED : 8'($urandom_range(255));
                send_rx_byte(b, 1'b0, 1'b0, NO_RESULT);
            end
        end else begin
            if (pick < 72)      len = $urandom_range(0, 12);
            else if (pick < 90) len = $urandom_range(13, MAX_FRAME_BYTES_DEF);
            else                len = $urandom_range(MAX_FRAME_BYTES_DEF + 1,
                                                     MAX_FRAME_BYTES_DEF + 6);
            for (k = 0; k < len; k++) begin
                b = ($urandom_range(9) == 0) ? CARRIAGE_RETURN : 8'($urandom_range(255));
                if (b == LINE_FEED) b = 8'h8A;
                send_rx_byte(b, 1'b0, 1'b0, NO_RESULT);
            end
            if ($urandom_range(3) == 0) send_rx_byte(CARRIAGE_RETURN, 1'b0, 1'b0, NO_RESULT);
            send_rx_byte(LINE_FEED, 1'b0, 1'b0, NO_RESULT);
        end
    endtask

    // stop offering and let every outstanding result come out
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (frame_q.size() != 0);
    endtask

    // receiver: random stalls, or a long hold-off when requested
    initial begin : receiver
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_rx_req) begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
                hold_rx_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[14:8], m_axis_tlast};
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got_res);
                mismatches++;
            end else begin
                want_res = frame_q.pop_front();
                check_field("result_kind", want_res.kind, got_res.kind);
                check_field("frame_byte", want_res.fbyte, got_res.fbyte);
                check_field("line_len", want_res.flen, got_res.flen);
                check_field("last_of_run", want_res.flast, got_res.flast);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int unsigned r;
        int unsigned k;
        int unsigned phase;
        int unsigned phase_end;
        int unsigned idle_pcts  [4];
        int unsigned stall_pcts [4];
        idle_pcts  = '{0, 65, 0, 12};
        stall_pcts = '{0, 0, 65, 12};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (r = 0; r < N_ROWS; r++) begin
            for (k = 0; k < DIRECTED_ROWS[r].reps; k++) begin
                send_rx_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].typed,
                             DIRECTED_ROWS[r].n_typed, DIRECTED_ROWS[r].typed_res);
            end
        end
        wait_all_results();

        // random lines under each idling mix
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            phase_end      = rx_sent + PHASE_BYTES;
            while (rx_sent < phase_end) send_random_line();
            wait_all_results();
        end

        // receiver holds off while short lines keep coming, so input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_rx_req    = 1'b1;
        for (k = 0; k < 40; k++) begin
            send_rx_byte((k % 10 == 9) ? LINE_FEED : 8'($urandom_range(32, 126)),
                         1'b0, 1'b0, NO_RESULT);
        end
        while (hold_rx_req) @(posedge i_clk);
        wait_all_results();

        // drain and report
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
